### sv/phe_pkg.sv
// Package: constants, log table and controller interface types for the entropy block.
package phe_pkg;
   localparam int ImageWidth  = 64;
   localparam int ImageHeight = 64;
   localparam int NumBins     = 16;
   localparam int BinWidth    = 16;
   localparam int ColW        = 6;
   localparam int RowW        = 6;
   localparam int PosW        = 12;
   localparam int BinW        = 4;
   localparam int Positions   = 4096;
   localparam int BinDepth    = 65536;
   localparam int BinAddrW    = 16;
   localparam int CntW        = 16;
   localparam int EntW        = 15;
   localparam int RateW       = 17;
   localparam int WsumW       = 40;
   localparam int DivW        = 21;
   localparam logic [RateW-1:0] RateOne  = 17'd65536;
   localparam logic [RateW-1:0] RateRst  = 17'd6554;
   localparam logic [CntW-1:0]  ThreshRst = 16'd16;
   localparam logic [0:0] CsrRate   = 1'b0;
   localparam logic [0:0] CsrThresh = 1'b1;

   function automatic logic [16:0] log_frac(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0: v = 17'd0;      5'd1: v = 17'd5732;   5'd2: v = 17'd11136;
         5'd3: v = 17'd16248;  5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
         5'd6: v = 17'd30109;  5'd7: v = 17'd34312;  5'd8: v = 17'd38336;
         5'd9: v = 17'd42196;  5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
         5'd12: v = 17'd52911; 5'd13: v = 17'd56229; 5'd14: v = 17'd59434;
         5'd15: v = 17'd62534; 5'd16: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // Q5.16 log2, 0 for x == 0
   function automatic logic [20:0] log2_q16(input logic [15:0] x);
      logic [3:0]  e;
      logic [15:0] f;
      logic [31:0] sh;
      logic [16:0] lo;
      logic [16:0] hi;
      logic [28:0] prod;
      e = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (x[i]) e = 4'(i);
      end
      sh = {16'd0, x} << (5'd16 - {1'b0, e});
      f = sh[15:0];
      lo = log_frac({1'b0, f[15:12]});
      hi = log_frac({1'b0, f[15:12]} + 5'd1);
      prod = 29'(hi - lo) * 29'(f[11:0]);
      if (x == 16'd0) return 21'd0;
      return {1'b0, e, 16'd0} + 21'(lo) + 21'(prod[28:12]);
   endfunction

   typedef struct packed {
      logic start;
      logic rd_bin;
      logic wr_bin_inc;
      logic rd_walk;
      logic clr_walk;
      logic acc;
      logic div_start;
      logic blend;
      logic wr_result;
      logic [BinW-1:0] walk_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic in_range;
      logic trigger;
      logic div_busy;
   } ctl_sts_type;
endpackage

### sv/pixel_histogram_entropy_ema.sv
// Top level: per-position histogram entropy with smoothing.
// channel | dir | tdata (low bit up)                      | tuser
// req     | in  | pixel_col[5:0] pixel_row[11:6] int[19:12] | -
// rsp     | out | entropy_value[14:0]                     | was_updated
// csr     | in  | index 0 blend_rate, 1 sample_threshold  | -
// One pixel at a time; a pixel that triggers an update also runs
// the 16-bin walk and the 40-step bit-serial divider.
// After reset a clearing pass zeroes the stores; req_tready low.
// A stalled result holds the next pixel until it is taken.
module pixel_histogram_entropy_ema import phe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_col, pixel_row, intensity, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // entropy_value, zero pad
   output logic        rsp_tuser,   // was_updated
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   logic [RateW-1:0] rate_ff;
   logic [CntW-1:0] thr_ff;
   logic clr_active;
   logic [BinAddrW-1:0] clr_addr;
   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic [EntW-1:0] ent;
   logic upd;
   logic [EntW-1:0] rsp_e_ff;
   logic rsp_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RateRst;
         thr_ff <= ThreshRst;
      end else if (csr_we) begin
         case (csr_index)
            CsrRate: rate_ff <= csr_wdata;
            CsrThresh: thr_ff <= csr_wdata[CntW-1:0];
            default: ;
         endcase
      end
   end

   phe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .clr_active(clr_active),
      .clr_addr(clr_addr), .cmd(cmd), .sts(sts));

   phe_dp u_dp (
      .clock(clock), .reset(reset), .in_col(req_tdata[5:0]), .in_row(req_tdata[11:6]),
      .in_level(req_tdata[19:12]), .blend_rate(rate_ff), .sample_threshold(thr_ff),
      .clr_active(clr_active), .clr_addr(clr_addr), .cmd(cmd), .sts(sts),
      .out_entropy(ent), .out_updated(upd));

   // result register loads whenever it is empty or its result is being taken
   always_ff @(posedge clock) begin
      if (!rsp_tvalid || rsp_tready) begin
         rsp_e_ff <= ent;
         rsp_u_ff <= upd;
      end
   end
   assign rsp_tdata = {1'b0, rsp_e_ff};
   assign rsp_tuser = rsp_u_ff;
endmodule

### sv/phe_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module phe_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### sv/phe_ctrl.sv
// Sequencer: reset clearing pass, bin update, histogram walk, divide, blend.
module phe_ctrl import phe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        clr_active,
   output logic [BinAddrW-1:0] clr_addr,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);
   localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StRead = 4'd2, StUpd = 4'd3,
      StWalkRd = 4'd4, StWalk = 4'd5, StLast = 4'd6, StDivGo = 4'd7, StDiv = 4'd8,
      StBlend = 4'd9, StWrite = 4'd10, StOut = 4'd11;
   logic [3:0] state_ff, state_in;
   logic [BinAddrW:0] clr_ff, clr_in;
   logic [BinW-1:0] idx_ff, idx_in;
   logic rsp_v_ff, rsp_v_in;

   assign clr_active = (state_ff == StClear);
   assign clr_addr = clr_ff[BinAddrW-1:0];
   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_v_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      idx_in = idx_ff;
      rsp_v_in = rsp_v_ff;
      cmd = '0;
      cmd.walk_idx = idx_ff;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         StClear: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BinAddrW+1)'(BinDepth - 1)) state_in = StIdle;
         end
         StIdle: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in = StRead;
            end
         end
         StRead: begin
            if (!sts.in_range) begin
               state_in = StOut;
            end else begin
               cmd.rd_bin = 1'b1;
               state_in = StUpd;
            end
         end
         StUpd: begin
            cmd.wr_bin_inc = 1'b1;
            idx_in = '0;
            state_in = sts.trigger ? StWalkRd : StWrite;
         end
         StWalkRd: begin
            state_in = StWalk;
         end
         StWalk: begin
            cmd.acc = 1'b1;
            cmd.clr_walk = 1'b1;
            cmd.rd_walk = 1'b1;
            cmd.walk_idx = idx_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == BinW'(NumBins - 1)) state_in = StLast;
         end
         StLast: begin
            cmd.acc = 1'b1;
            cmd.clr_walk = 1'b1;
            state_in = StDivGo;
         end
         StDivGo: begin
            cmd.div_start = 1'b1;
            state_in = StDiv;
         end
         StDiv: begin
            if (!sts.div_busy) state_in = StBlend;
         end
         StBlend: begin
            cmd.blend = 1'b1;
            state_in = StWrite;
         end
         StWrite: begin
            cmd.wr_result = 1'b1;
            state_in = StOut;
         end
         StOut: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         clr_ff <= '0;
         idx_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         idx_ff <= idx_in;
         rsp_v_ff <= rsp_v_in;
      end
   end
endmodule

### sv/phe_div.sv
// Radix-2 restoring divider: 40-bit weighted sum by 16-bit total, quotient saturated to 21 bits.
module phe_div import phe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WsumW-1:0]  dividend,
   input  logic [CntW-1:0]   divisor,
   output logic              busy,
   output logic [DivW-1:0]   quotient
);
   logic [WsumW-1:0] q_ff, q_in;
   logic [CntW:0]    r_ff, r_in;
   logic [5:0]       n_ff, n_in;
   logic             busy_ff, busy_in;
   logic [CntW:0]    trial;
   logic             sat;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      trial = {r_ff[CntW-1:0], q_ff[WsumW-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         n_in = 6'(WsumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[WsumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[WsumW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == 6'd1) busy_in = 1'b0;
      end
   end

   // quotient beyond 21 bits far exceeds log2(total); saturate
   assign sat = |q_ff[WsumW-1:DivW];
   assign quotient = sat ? '1 : q_ff[DivW-1:0];
   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end
endmodule

### sv/phe_dp.sv
// Datapath: histogram and total memories, entropy accumulate, divide and blend.
module phe_dp import phe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [ColW-1:0]   in_col,
   input  logic [RowW-1:0]   in_row,
   input  logic [7:0]        in_level,
   input  logic [RateW-1:0]  blend_rate,
   input  logic [CntW-1:0]   sample_threshold,
   input  logic              clr_active,
   input  logic [BinAddrW-1:0] clr_addr,
   input  ctl_cmd_type       cmd,
   output ctl_sts_type       sts,
   output logic [EntW-1:0]   out_entropy,
   output logic              out_updated
);
   logic [PosW-1:0] pos_ff;
   logic [BinW-1:0] bin_ff;
   logic            inr_ff;
   logic [EntW-1:0] res_ff;
   logic            upd_ff;
   logic [CntW-1:0] tot_ff;
   logic [WsumW-1:0] wsum_ff;
   logic [20:0]     h_ff;
   logic [EntW-1:0] old_ff;
   logic [CntW-1:0] cnt_ff;
   logic [20:0]     lg_ff;
   logic [CntW-1:0] bin_rd, tot_rd;
   logic [EntW-1:0] ent_rd;
   logic [BinAddrW-1:0] b_wa, b_ra;
   logic [CntW-1:0] b_wd;
   logic b_we;
   logic [PosW-1:0] p_wa;
   logic t_we, e_we;
   logic [CntW-1:0] t_wd, tot_new;
   logic [EntW-1:0] e_wd;
   logic div_busy;
   logic [DivW-1:0] avg;
   logic [20:0] lt;
   logic [20:0] hdiff;
   logic [16:0] hq;
   logic [EntW-1:0] hsat;
   logic [RateW-1:0] rate;
   logic [33:0] mix;
   logic [17:0] mixs;
   logic [BinW-1:0] bin_c;
   logic [7:0] bq;

   assign bq = in_level / 8'(BinWidth);
   assign bin_c = (bq >= 8'(NumBins)) ? BinW'(NumBins - 1) : bq[BinW-1:0];
   assign tot_new = (tot_rd == 16'hFFFF) ? tot_rd : tot_rd + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         inr_ff <= (32'(in_col) < ImageWidth) && (32'(in_row) < ImageHeight);
         pos_ff <= PosW'(32'(in_row) * ImageWidth + 32'(in_col));
         bin_ff <= bin_c;
         upd_ff <= 1'b0;
         res_ff <= '0;
         wsum_ff <= '0;
         cnt_ff <= '0;
         lg_ff <= '0;
      end
      if (cmd.wr_bin_inc) begin
         tot_ff <= tot_new;
         res_ff <= ent_rd;
         old_ff <= ent_rd;
      end
      if (cmd.rd_walk) begin
         cnt_ff <= bin_rd;
         lg_ff <= log2_q16(bin_rd);
      end
      if (cmd.acc) wsum_ff <= wsum_ff + WsumW'(cnt_ff) * WsumW'(lg_ff);
      if (cmd.div_start) h_ff <= log2_q16(tot_ff);
      if (cmd.blend) begin
         res_ff <= mixs > 18'd32767 ? 15'd32767 : mixs[EntW-1:0];
         upd_ff <= 1'b1;
      end
   end

   // bin memory address muxing
   always_comb begin
      b_ra = {pos_ff, cmd.walk_idx};
      if (cmd.start || cmd.rd_bin) b_ra = {pos_ff, bin_ff};
      b_we = 1'b0;
      b_wa = {pos_ff, bin_ff};
      b_wd = (bin_rd == 16'hFFFF) ? bin_rd : bin_rd + 1'b1;
      if (clr_active) begin
         b_we = 1'b1;
         b_wa = clr_addr;
         b_wd = '0;
      end else if (cmd.wr_bin_inc) begin
         b_we = 1'b1;
      end else if (cmd.clr_walk) begin
         b_we = 1'b1;
         b_wa = {pos_ff, cmd.walk_idx - 1'b1};
         b_wd = '0;
      end
   end

   always_comb begin
      p_wa = pos_ff;
      t_we = 1'b0;
      t_wd = tot_new;
      e_we = 1'b0;
      e_wd = res_ff;
      if (clr_active) begin
         p_wa = clr_addr[PosW-1:0];
         t_we = 1'b1;
         t_wd = '0;
         e_we = 1'b1;
         e_wd = '0;
      end else begin
         if (cmd.wr_bin_inc) t_we = 1'b1;
         if (cmd.wr_bin_inc && sts.trigger) t_wd = '0;
         if (cmd.wr_result) e_we = 1'b1;
      end
   end

   assign sts.in_range = inr_ff;
   assign sts.trigger = tot_new >= sample_threshold;
   assign sts.div_busy = div_busy;

   phe_ram #(.Width(CntW), .Depth(BinDepth)) u_bins (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(bin_rd));
   phe_ram #(.Width(CntW), .Depth(Positions)) u_totals (
      .clock(clock), .wr_en(t_we), .wr_addr(p_wa), .wr_data(t_wd),
      .rd_addr(pos_ff), .rd_data(tot_rd));
   phe_ram #(.Width(EntW), .Depth(Positions)) u_ent (
      .clock(clock), .wr_en(e_we), .wr_addr(p_wa), .wr_data(e_wd),
      .rd_addr(pos_ff), .rd_data(ent_rd));

   phe_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(wsum_ff),
      .divisor(tot_ff), .busy(div_busy), .quotient(avg));

   assign lt = h_ff;
   assign hdiff = (lt > avg) ? lt - avg : 21'd0;
   assign hq = 17'((22'(hdiff) + 22'd8) >> 4);
   assign hsat = (hq > 17'd32767) ? 15'd32767 : hq[EntW-1:0];
   assign rate = (blend_rate > RateOne) ? RateOne : blend_rate;
   assign mix = 34'(RateOne - rate) * 34'(old_ff) + 34'(rate) * 34'(hsat) + 34'd32768;
   assign mixs = mix[33:16];

   assign out_entropy = inr_ff ? res_ff : '0;
   assign out_updated = inr_ff & upd_ff;
endmodule

### test/tb_top.sv
// Testbench for pixel_histogram_entropy_ema: directed table, then random phases vs. a predictor.
`timescale 1ns / 1ps
module tb_top;
   import phe_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam int SettleCycles = 100;

   typedef struct {
      logic [14:0] entropy;
      logic        updated;
   } entropy_result_type;

   typedef struct {
      bit          is_csr;
      logic [0:0]  idx;
      logic [16:0] val;
      logic [5:0]  col;
      logic [5:0]  row;
      logic [7:0]  lvl;
      bit          typed;
      logic [14:0] ent;
      bit          upd;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [16:0] csr_wdata;

   logic [15:0] hist_bins [0:BinDepth-1];
   logic [15:0] pos_totals [0:Positions-1];
   logic [14:0] pos_entropy [0:Positions-1];
   logic [16:0] cur_rate;
   logic [15:0] cur_thresh;

   entropy_result_type pending_results[$];
   int errors = 0;
   int rsp_count = 0;
   int update_count = 0;
   int cycles = 0;
   int long_hold = 0;

   pixel_histogram_entropy_ema uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned log2_fix(input int unsigned x);
      int unsigned frac_tab [0:16] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
         38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
      int unsigned e, f, k, r;
      if (x == 0) return 0;
      e = 0;
      while (e < 15 && (x >> (e + 1)) != 0) e++;
      f = (x << (16 - e)) & 32'hFFFF;
      k = f >> 12;
      r = f & 32'hFFF;
      return (e << 16) + frac_tab[k] + (((frac_tab[k+1] - frac_tab[k]) * r) >> 12);
   endfunction

   function automatic entropy_result_type predict_entropy(input logic [5:0] col,
         input logic [5:0] row, input logic [7:0] lvl);
      entropy_result_type res;
      int unsigned pos, base, bin, total, avg, lt, h, rate;
      longint unsigned weighted, mix;
      pos = 32'({row, col});
      base = pos * NumBins;
      bin = lvl / BinWidth;
      if (bin >= NumBins) bin = NumBins - 1;
      if (hist_bins[base+bin] != 16'hFFFF) hist_bins[base+bin]++;
      if (pos_totals[pos] != 16'hFFFF) pos_totals[pos]++;
      res.updated = 0;
      if (pos_totals[pos] >= cur_thresh) begin
         total = pos_totals[pos];
         weighted = 0;
         for (int i = 0; i < NumBins; i++)
            weighted += longint'(hist_bins[base+i]) * log2_fix(hist_bins[base+i]);
         avg = 32'(weighted / total);
         lt = log2_fix(total);
         h = (lt > avg) ? lt - avg : 0;
         h = (h + 8) >> 4;
         if (h > 32767) h = 32767;
         rate = (cur_rate > 65536) ? 65536 : cur_rate;
         mix = longint'(65536 - rate) * pos_entropy[pos] + longint'(rate) * h + 32768;
         mix = mix >> 16;
         pos_entropy[pos] = (mix > 32767) ? 15'h7FFF : mix[14:0];
         for (int i = 0; i < NumBins; i++) hist_bins[base+i] = 0;
         pos_totals[pos] = 0;
         res.updated = 1;
      end
      res.entropy = pos_entropy[pos];
      return res;
   endfunction

   task automatic send_pixel(input logic [5:0] col, input logic [5:0] row,
         input logic [7:0] lvl, input bit typed, input logic [14:0] ent, input bit upd);
      int gap;
      entropy_result_type res;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, lvl, row, col};
      do @(posedge clock); while (!req_tready);
      res = predict_entropy(col, row, lvl);
      if (typed) begin
         res.entropy = ent;
         res.updated = upd;
      end
      pending_results = {pending_results, res};
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [16:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CsrRate) cur_rate = val;
      else cur_thresh = val[15:0];
   endtask

   // result side
   initial begin
      entropy_result_type exp_res;
      int stall;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         if (long_hold > 0) begin
            rsp_tready <= 0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end
         stall = $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
         if (rsp_tuser) update_count++;
         if (pending_results.size() == 0) begin
            errors++;
            $error("unexpected transaction: entropy_value %0d", rsp_tdata[14:0]);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[14:0] !== exp_res.entropy) begin
               errors++;
               $error("entropy_value exp %0d got %0d", exp_res.entropy, rsp_tdata[14:0]);
            end
            if (rsp_tuser !== exp_res.updated) begin
               errors++;
               $error("was_updated exp %0d got %0d", exp_res.updated, rsp_tuser);
            end
         end
      end
   end

   initial begin
      stim_row_type dir_rows[$];
      logic [16:0] phase_rate [0:7] = '{6554, 65536, 0, 131071, 30000, 1, 65535, 100000};
      logic [15:0] phase_thr [0:7] = '{16, 1, 3, 0, 5, 65535, 2, 8};
      logic [11:0] hot_pos [0:3];
      logic [11:0] p;
      stim_row_type s;
      int n;

      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_we = 0;
      csr_index = CsrRate;
      csr_wdata = 0;
      for (int i = 0; i < BinDepth; i++) hist_bins[i] = 0;
      for (int i = 0; i < Positions; i++) begin
         pos_totals[i] = 0;
         pos_entropy[i] = 0;
      end
      cur_rate = RateRst;
      cur_thresh = ThreshRst;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir_rows = '{
         '{0, CsrRate, 0, 0, 0, 0, 1, 0, 0},
         '{0, CsrRate, 0, 63, 63, 255, 1, 0, 0},
         '{0, CsrRate, 0, 63, 0, 128, 1, 0, 0},
         '{0, CsrRate, 0, 0, 63, 15, 1, 0, 0},
         '{0, CsrRate, 0, 21, 42, 170, 0, 0, 0},
         '{1, CsrRate, 131071, 0, 0, 0, 0, 0, 0},
         '{1, CsrThresh, 0, 0, 0, 0, 0, 0, 0},
         '{0, CsrRate, 0, 5, 5, 77, 1, 0, 1},
         '{0, CsrRate, 0, 0, 0, 16, 1, 4096, 1},
         '{1, CsrThresh, 2, 0, 0, 0, 0, 0, 0},
         '{0, CsrRate, 0, 9, 9, 0, 1, 0, 0},
         '{0, CsrRate, 0, 9, 9, 0, 1, 0, 1},
         '{1, CsrRate, 0, 0, 0, 0, 0, 0, 0},
         '{0, CsrRate, 0, 63, 63, 240, 0, 0, 0},
         '{1, CsrThresh, 1, 0, 0, 0, 0, 0, 0},
         '{0, CsrRate, 0, 1, 2, 255, 0, 0, 0},
         '{1, CsrRate, 32768, 0, 0, 0, 0, 0, 0},
         '{0, CsrRate, 0, 0, 0, 200, 0, 0, 0}
      };
      foreach (dir_rows[i]) begin
         s = dir_rows[i];
         if (s.is_csr) begin
            wait_idle();
            write_csr(s.idx, s.val);
         end else
            send_pixel(s.col, s.row, s.lvl, s.typed, s.ent, s.upd);
      end

      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         write_csr(CsrRate, phase_rate[ph]);
         write_csr(CsrThresh, phase_thr[ph]);
         for (int i = 0; i < 4; i++) hot_pos[i] = 12'($urandom);
         if (ph == 1) long_hold = 400;
         n = (phase_thr[ph] == 16'hFFFF) ? 100 : 240;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85) p = hot_pos[$urandom_range(0, 3)];
            else p = 12'($urandom);
            if ($urandom_range(0, 3) == 0)
               send_pixel(p[5:0], p[11:6], 8'($urandom_range(0, 2) * 127), 0, 0, 0);
            else
               send_pixel(p[5:0], p[11:6], 8'($urandom_range(0, 255)), 0, 0, 0);
         end
      end
      wait_idle();

      $display("Checked %0d results (%0d entropy updates) over 8 register settings",
               rsp_count, update_count);
      $display("including zero threshold, rate above one and a long output stall");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
